// File: hdl/rcca_pkg.sv
// Package: shared types and codes for the refcount compacting allocator.
package rcca_pkg;
  localparam int MODE_W   = 2;
  localparam int SIZE_W   = 17;
  localparam int REF_W    = 16;
  localparam int STATUS_W = 3;
  localparam int OBJ_W    = 9;
  localparam int BYTES_W  = 17;
  localparam int CNT_W    = 16;

  localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RETRIEVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADD      = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DROP     = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_REF   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd5;

  // One table entry: reference, start offset, size, count.
  localparam int ENTRY_W = REF_W + REF_W + BYTES_W + CNT_W;

  typedef struct packed {
    logic [REF_W-1:0]   id;
    logic [REF_W-1:0]   start;
    logic [BYTES_W-1:0] bytes;
    logic [CNT_W-1:0]   count;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SEARCH,
    S_SEARCH_WAIT,
    S_FOUND,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_COMPACT_RD,
    S_COMPACT_WR,
    S_INSERT,
    S_RESULT
  } state_t;
endpackage

// File: hdl/rcca_ram.sv
// Generic single-port write, single-port read RAM with registered read.
module rcca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/refcount_compacting_allocator_unit.sv
// Top level: refcount compacting allocator with table in one RAM.
//
// One operation per input transaction, one result transaction per operation.
// The object table sits in one RAM (one entry per slot, packed in allocation
// order); a sequencer does read-modify-write over it, one slot at a time.
// Bad-size and exhausted inserts return without touching the table; retrieve,
// add and drop search the slots in order up to the match; a drop that frees an
// object shifts every later slot down by one; an insert that does not fit first
// compacts the live objects to the bottom of the pool. Results sit in an output
// register; input is accepted once the previous result has been taken. No
// clearing pass after reset: only slots below the live count are ever read.
module refcount_compacting_allocator_unit
  import rcca_pkg::*;
#(
  parameter int POOL_BYTES  = 65536,
  parameter int MAX_OBJECTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] mode, [18:2] size, [34:19] ref_req, [39:35] zero
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] status, [18:3] new_ref, [34:19] offset, [43:35] objects,
  // [60:44] bytes_in_use, [61] compacted, [78:62] freed_before_compact,
  // [79] zero
  output logic [79:0] m_tdata
);
  localparam int AW = $clog2(MAX_OBJECTS);
  localparam int LW = AW + 1;  // live count holds MAX_OBJECTS itself

  state_t state, state_next;

  logic [MODE_W-1:0]  op_mode;
  logic [SIZE_W-1:0]  op_size;
  logic [REF_W-1:0]   op_ref;

  logic [LW-1:0]      live;
  logic [BYTES_W-1:0] bump;
  logic [REF_W-1:0]   next_id;
  logic [BYTES_W-1:0] live_bytes;
  logic [BYTES_W-1:0] released;

  logic [LW-1:0]      idx;       // walk position
  logic [BYTES_W-1:0] pos;       // compaction running offset
  logic [STATUS_W-1:0] r_status;
  logic [REF_W-1:0]   r_new_ref;
  logic [REF_W-1:0]   r_offset;
  logic               r_comp;
  logic [BYTES_W-1:0] r_freed;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  entry_t             wdata, rdata;

  rcca_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_OBJECTS)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_RESULT);
  assign m_tdata  = {1'b0, r_freed, r_comp, live_bytes, OBJ_W'(live),
                     r_offset, r_new_ref, r_status};

  // sums kept one bit wider than the pool bound
  logic [BYTES_W:0] bump_sum;
  assign bump_sum = {1'b0, bump} + {1'b0, op_size};
  logic [BYTES_W:0] rel_sum;
  assign rel_sum  = {1'b0, released} + {1'b0, rdata.bytes};

  logic [CNT_W-1:0] cnt_dec;
  assign cnt_dec = (rdata.count != '0) ? rdata.count - 1'b1 : rdata.count;

  always_comb begin
    state_next = state;
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = rdata;
    raddr = idx[AW-1:0];
    unique case (state)
      S_IDLE:        if (s_tvalid) state_next = S_DECIDE;
      S_DECIDE: begin
        if (op_mode == MODE_INSERT) begin
          if (op_size == '0 || {15'd0, op_size} > POOL_BYTES) state_next = S_RESULT;
          else if ({{(32-LW){1'b0}}, live} >= MAX_OBJECTS || next_id == '0)
            state_next = S_RESULT;
          else if ({{(31-BYTES_W){1'b0}}, bump_sum} > POOL_BYTES) begin
            state_next = (live == '0) ? S_INSERT : S_COMPACT_RD;
          end else state_next = S_INSERT;
        end else if (op_ref == '0 || live == '0) state_next = S_RESULT;
        else state_next = S_SEARCH;
      end
      S_SEARCH:      state_next = S_SEARCH_WAIT;   // read issued at idx
      S_SEARCH_WAIT: begin
        if (rdata.id == op_ref) state_next = S_FOUND;
        else if (idx + 1'b1 >= live) state_next = S_RESULT;
        else state_next = S_SEARCH;
      end
      S_FOUND: begin
        state_next = S_RESULT;
        if (op_mode == MODE_ADD && rdata.count != '1) begin
          we = 1'b1;
          wdata.count = rdata.count + 1'b1;
        end else if (op_mode == MODE_DROP) begin
          if (cnt_dec != '0) begin
            we = 1'b1;
            wdata.count = cnt_dec;
          end else if (idx + 1'b1 < live) begin
            state_next = S_SHIFT_RD;
          end
        end
      end
      S_SHIFT_RD: begin
        raddr = AW'(idx + 1'b1);
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        we = 1'b1;
        wdata = rdata;
        state_next = (idx + 2'd2 < live) ? S_SHIFT_RD : S_RESULT;
      end
      S_COMPACT_RD:  state_next = S_COMPACT_WR;
      S_COMPACT_WR: begin
        we = 1'b1;
        wdata.start = pos[REF_W-1:0];
        state_next = (idx + 1'b1 < live) ? S_COMPACT_RD : S_INSERT;
      end
      S_INSERT: begin
        state_next = S_RESULT;
        if ({{(31-BYTES_W){1'b0}}, bump_sum} <= POOL_BYTES) begin
          we = 1'b1;
          waddr = live[AW-1:0];
          wdata.id = next_id;
          wdata.start = bump[REF_W-1:0];
          wdata.bytes = op_size;
          wdata.count = CNT_W'(1);
        end
      end
      S_RESULT:      if (m_tready) state_next = S_IDLE;
      default:       state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live       <= '0;
      bump       <= '0;
      next_id    <= REF_W'(1);
      live_bytes <= '0;
      released   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          op_mode   <= s_tdata[1:0];
          op_size   <= s_tdata[18:2];
          op_ref    <= s_tdata[34:19];
          idx       <= '0;
          pos       <= '0;
          r_status  <= ST_OK;
          r_new_ref <= '0;
          r_offset  <= '0;
          r_comp    <= 1'b0;
          r_freed   <= '0;
        end
        S_DECIDE: begin
          if (op_mode == MODE_INSERT) begin
            if (op_size == '0 || {15'd0, op_size} > POOL_BYTES) r_status <= ST_BAD_SIZE;
            else if ({{(32-LW){1'b0}}, live} >= MAX_OBJECTS || next_id == '0)
              r_status <= ST_EXHAUSTED;
            else if ({{(31-BYTES_W){1'b0}}, bump_sum} > POOL_BYTES) begin
              r_comp   <= 1'b1;
              r_freed  <= released;
              released <= '0;
              if (live == '0) bump <= '0;
            end
          end else if (op_ref == '0 || live == '0) begin
            r_status <= (op_mode == MODE_RETRIEVE) ? ST_BAD_REF : ST_IGNORED;
          end
        end
        S_SEARCH_WAIT: begin
          if (rdata.id != op_ref) begin
            idx <= idx + 1'b1;
            if (idx + 1'b1 >= live) r_status <= ST_BAD_REF;
          end
        end
        S_FOUND: begin
          if (op_mode == MODE_RETRIEVE) r_offset <= rdata.start;
          else if (op_mode == MODE_ADD) begin
            if (rdata.count == '1) r_status <= ST_EXHAUSTED;
          end else if (cnt_dec == '0) begin
            released   <= rel_sum[BYTES_W] ? '1 : rel_sum[BYTES_W-1:0];
            live_bytes <= (live_bytes >= rdata.bytes) ? live_bytes - rdata.bytes : '0;
            if (idx + 1'b1 >= live) live <= live - 1'b1;
          end
        end
        S_SHIFT_WR: begin
          idx <= idx + 1'b1;
          if (idx + 2'd2 >= live) live <= live - 1'b1;
        end
        S_COMPACT_WR: begin
          pos <= pos + rdata.bytes;
          idx <= idx + 1'b1;
          if (idx + 1'b1 >= live) bump <= pos + rdata.bytes;
        end
        S_INSERT: begin
          if ({{(31-BYTES_W){1'b0}}, bump_sum} <= POOL_BYTES) begin
            live       <= live + 1'b1;
            r_new_ref  <= next_id;
            r_offset   <= bump[REF_W-1:0];
            next_id    <= next_id + 1'b1;
            bump       <= bump_sum[BYTES_W-1:0];
            live_bytes <= live_bytes + op_size;
          end else begin
            r_status <= ST_NO_SPACE;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// File: hdl/rcca_checker.sv
// Port-level checker for the allocator, bound to the top level.
module rcca_checker
  import rcca_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);
  // no new input while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken with result pending");
  // held result stays stable
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed");
  // a waiting input transaction is held unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
    else $error("input changed while waiting");
  // a failed operation never hands out a reference
  a_newref: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[18:3] == 16'd0)
    else $error("new_ref on failure");
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= ST_EXHAUSTED) else $error("bad status code");
endmodule

bind refcount_compacting_allocator_unit rcca_checker u_rcca_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
